// ===== design/mplm_pkg.sv =====
package mplm_pkg;

  localparam int ACC_WIDTH      = 24;
  localparam int PATH_FRAC_BITS = 8;
  localparam int PATH_W         = 32;
  localparam int SCALE_W        = 16;
  localparam int SCALE_FRAC     = 16;
  localparam int SQ_W           = 16;
  localparam int RAD_W          = SQ_W + 2 * PATH_FRAC_BITS;
  localparam int ROOT_W         = RAD_W / 2;
  localparam int PROD_W         = PATH_W + SCALE_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1470;
  localparam logic [7:0]         OVF_MASK    = 8'hC0;
  localparam logic [7:0]         LEFT_MASK   = 8'h01;

  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_MEAS  = 2'd2;
  localparam logic [1:0] PH_ENDED = 2'd3;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT   = 4'd0;
  localparam pc_t PC_UPDATE = 4'd1;
  localparam pc_t PC_SQINIT = 4'd2;
  localparam pc_t PC_SQSTEP = 4'd3;
  localparam pc_t PC_ACCUM  = 4'd4;
  localparam pc_t PC_MULX   = 4'd5;
  localparam pc_t PC_MULY   = 4'd6;
  localparam pc_t PC_MULP   = 4'd7;
  localparam pc_t PC_EMIT   = 4'd8;

  typedef struct packed {
    logic [7:0]        status_byte;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } pkt_t;

  typedef struct packed {
    logic [1:0]                  phase;
    logic                        finished;
    logic                        ovf_err;
    logic signed [ACC_WIDTH-1:0] sum_x;
    logic signed [ACC_WIDTH-1:0] sum_y;
    logic signed [ACC_WIDTH-1:0] x_mm;
    logic signed [ACC_WIDTH-1:0] y_mm;
    logic [PATH_W-1:0]           path_mm_q8;
  } res_t;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_UPDATE,
    OP_SQINIT,
    OP_SQSTEP,
    OP_ACCUM,
    OP_MULX,
    OP_MULY,
    OP_MULP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ITEM,
    COND_NOT_MEAS,
    COND_SQ_LAST,
    COND_OUT_FREE
  } cond_e;

  // taken jump goes to target, else hold stays put or falls through
  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  hold;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    case (pc)
      PC_WAIT:   w = '{op: OP_WAIT,   cond: COND_ITEM,     hold: 1'b1, target: PC_UPDATE};
      PC_UPDATE: w = '{op: OP_UPDATE, cond: COND_NOT_MEAS, hold: 1'b0, target: PC_MULX};
      PC_SQINIT: w = '{op: OP_SQINIT, cond: COND_NEVER,    hold: 1'b0, target: PC_WAIT};
      PC_SQSTEP: w = '{op: OP_SQSTEP, cond: COND_SQ_LAST,  hold: 1'b1, target: PC_ACCUM};
      PC_ACCUM:  w = '{op: OP_ACCUM,  cond: COND_NEVER,    hold: 1'b0, target: PC_WAIT};
      PC_MULX:   w = '{op: OP_MULX,   cond: COND_NEVER,    hold: 1'b0, target: PC_WAIT};
      PC_MULY:   w = '{op: OP_MULY,   cond: COND_NEVER,    hold: 1'b0, target: PC_WAIT};
      PC_MULP:   w = '{op: OP_MULP,   cond: COND_NEVER,    hold: 1'b0, target: PC_WAIT};
      PC_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_FREE, hold: 1'b1, target: PC_WAIT};
      default:   w = '{op: OP_WAIT,   cond: COND_NEVER,    hold: 1'b0, target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== design/mouse_packet_length_meter_core.sv =====
// an item is taken in wait, then update; when measuring, square root init,
// the 16-step digit-by-digit square root loop and accumulate run, which the
// other phases skip; then x, y, path multiplies and emit, which waits on stall;
// the result shows the cycle after emit; no new item is taken until wait
// reset: phase 0, accumulators cleared, scale back to 1470, no result pending
module mouse_packet_length_meter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mplm_pkg::pkt_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mplm_pkg::res_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mplm_pkg::SCALE_W-1:0]   cfg_data_i
);
  import mplm_pkg::*;

  localparam logic [PATH_W-1:0] MM_POS_MAX = PATH_W'((64'd1 << (ACC_WIDTH - 1)) - 64'd1);
  localparam logic [PATH_W-1:0] MM_NEG_MAX = PATH_W'(64'd1 << (ACC_WIDTH - 1));
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   cond_met;

  pkt_t                  in_q;
  logic [1:0]            phase_q, phase_d;
  logic                  button_q, button_d;
  logic                  fin_q, fin_d;
  logic                  err_q, err_d;
  logic signed [ACC_WIDTH-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [PATH_W-1:0]     path_q, path_d;
  logic [SCALE_W-1:0]    scale_q;

  logic [RAD_W-1:0]      rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [RAD_W:0]        trial;
  logic signed [15:0]    dxx, dyy;
  logic [SQ_W-1:0]       sq;

  logic signed [ACC_WIDTH:0] sum_x_w, sum_y_w;
  logic [PATH_W:0]       path_sum;

  logic [PATH_W-1:0]     mul_a;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic signed [ACC_WIDTH-1:0] xmm_q, xmm_d, ymm_q, ymm_d;

  res_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic emit_fire;

  function automatic logic [ACC_WIDTH-1:0] to_mm(input logic [PROD_W-1:0] p,
                                                 input logic neg);
    logic [PATH_W-1:0] q;
    q = p[SCALE_FRAC +: PATH_W];
    if (neg) begin
      if (q > MM_NEG_MAX) q = MM_NEG_MAX;
      q = PATH_W'(0) - q;
    end else if (q > MM_POS_MAX) begin
      q = MM_POS_MAX;
    end
    return q[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [PATH_W-1:0] abs_acc(input logic signed [ACC_WIDTH-1:0] a);
    logic [ACC_WIDTH-1:0] m;
    m = a[ACC_WIDTH-1] ? ACC_WIDTH'(-a) : a;
    return PATH_W'(m);
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
      input logic signed [ACC_WIDTH:0] s);
    logic signed [ACC_WIDTH-1:0] r;
    if (s[ACC_WIDTH] == s[ACC_WIDTH-1]) r = s[ACC_WIDTH-1:0];
    else if (s[ACC_WIDTH]) r = ACC_MIN;
    else r = ACC_MAX;
    return r;
  endfunction

  assign uw          = ucode_rom(pc_q);
  assign in_stall_o  = (uw.op != OP_WAIT);
  assign cfg_ready_o = 1'b1;
  assign emit_fire   = (uw.op == OP_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (uw.cond)
      COND_ITEM:     cond_met = in_valid_i;
      COND_NOT_MEAS: cond_met = (phase_q != PH_MEAS);
      COND_SQ_LAST:  cond_met = bit_q[0];
      COND_OUT_FREE: cond_met = !out_valid_q || !out_stall_i;
      default:       cond_met = 1'b0;
    endcase
    if (cond_met) pc_d = uw.target;
    else if (uw.hold) pc_d = pc_q;
    else pc_d = pc_q + pc_t'(1);
  end

  // datapath helpers
  assign dxx      = in_q.dx * in_q.dx;
  assign dyy      = in_q.dy * in_q.dy;
  assign sq       = SQ_W'(dxx) + SQ_W'(dyy);
  assign trial    = {1'b0, root_q} + {1'b0, bit_q};
  assign sum_x_w  = {acc_x_q[ACC_WIDTH-1], acc_x_q} + (ACC_WIDTH+1)'(in_q.dx);
  assign sum_y_w  = {acc_y_q[ACC_WIDTH-1], acc_y_q} + (ACC_WIDTH+1)'(in_q.dy);
  assign path_sum = {1'b0, path_q} + (PATH_W+1)'(root_q[ROOT_W-1:0]);

  always_comb begin
    case (uw.op)
      OP_MULY: mul_a = abs_acc(acc_y_q);
      OP_MULP: mul_a = path_q;
      default: mul_a = abs_acc(acc_x_q);
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    button_d = button_q;
    fin_d    = fin_q;
    err_d    = err_q;
    acc_x_d  = acc_x_q;
    acc_y_d  = acc_y_q;
    path_d   = path_q;
    rem_d    = rem_q;
    root_d   = root_q;
    bit_d    = bit_q;
    prod_d   = prod_q;
    xmm_d    = xmm_q;
    ymm_d    = ymm_q;
    out_d    = out_q;
    case (uw.op)
      OP_UPDATE: begin
        fin_d = 1'b0;
        err_d = 1'b0;
        if (phase_q == PH_WAIT || phase_q == PH_ENDED) begin
          acc_x_d  = '0;
          acc_y_d  = '0;
          path_d   = '0;
          button_d = in_q.status_byte[0];
          phase_d  = PH_ARMED;
        end else if (phase_q == PH_ARMED && in_q.status_byte[0] != button_q) begin
          acc_x_d = '0;
          acc_y_d = '0;
          path_d  = '0;
          phase_d = PH_MEAS;
        end
      end
      OP_SQINIT: begin
        rem_d  = {sq, {(2*PATH_FRAC_BITS){1'b0}}};
        root_d = '0;
        bit_d  = RAD_W'(1) << (RAD_W - 2);
      end
      OP_SQSTEP: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_d  = rem_q - trial[RAD_W-1:0];
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      OP_ACCUM: begin
        acc_x_d = sat_acc(sum_x_w);
        acc_y_d = sat_acc(sum_y_w);
        path_d  = path_sum[PATH_W] ? {PATH_W{1'b1}} : path_sum[PATH_W-1:0];
        if ((in_q.status_byte & OVF_MASK) != '0) begin
          err_d   = 1'b1;
          phase_d = PH_ENDED;
        end else if ((in_q.status_byte & LEFT_MASK) != '0) begin
          fin_d   = 1'b1;
          phase_d = PH_ENDED;
        end
      end
      OP_MULX: prod_d = mul_a * scale_q;
      OP_MULY: begin
        xmm_d  = to_mm(prod_q, acc_x_q[ACC_WIDTH-1]);
        prod_d = mul_a * scale_q;
      end
      OP_MULP: begin
        ymm_d  = to_mm(prod_q, acc_y_q[ACC_WIDTH-1]);
        prod_d = mul_a * scale_q;
      end
      OP_EMIT: begin
        if (emit_fire) begin
          out_d.phase          = phase_q;
          out_d.finished       = fin_q;
          out_d.ovf_err        = err_q;
          out_d.sum_x          = acc_x_q;
          out_d.sum_y          = acc_y_q;
          out_d.x_mm           = xmm_q;
          out_d.y_mm           = ymm_q;
          out_d.path_mm_q8     = prod_q[SCALE_FRAC +: PATH_W];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (emit_fire) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_WAIT;
      phase_q     <= PH_WAIT;
      button_q    <= 1'b0;
      fin_q       <= 1'b0;
      err_q       <= 1'b0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      path_q      <= '0;
      scale_q     <= SCALE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      phase_q     <= phase_d;
      button_q    <= button_d;
      fin_q       <= fin_d;
      err_q       <= err_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
      path_q      <= path_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    prod_q <= prod_d;
    xmm_q  <= xmm_d;
    ymm_q  <= ymm_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // one item at a time through the sequencer
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while sequencer busy");

  // finished and error never reported together
  a_fin_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.finished && out_data_o.ovf_err))
    else $error("finished and ovf_err both set");

  // an ending item leaves the meter in phase 3
  a_end_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.finished || out_data_o.ovf_err))
      |-> (out_data_o.phase == PH_ENDED))
    else $error("ending item without ended phase");

  // once armed the meter never returns to the first-packet wait
  a_no_rewait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_WAIT) |=> (phase_q != PH_WAIT))
    else $error("phase fell back to wait");

endmodule

// ===== tb/sv/mouse_packet_length_meter_core_tb.sv =====
`timescale 1ns / 1ps

module mouse_packet_length_meter_core_tb;
  import mplm_pkg::*;

  localparam longint ACC_MAX = (longint'(1) << (ACC_WIDTH - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint PATH_MAX = (longint'(1) << PATH_W) - 1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  pkt_t                 in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  res_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [SCALE_W-1:0]   cfg_data_i = '0;

  mouse_packet_length_meter_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // packets waiting to be sent and results still owed by the block
  pkt_t pkt_queue[$];
  res_t meas_queue[$];

  // predicted meter state
  logic [1:0]         m_phase = PH_WAIT;
  logic               m_btn = 1'b0;
  longint             m_sum_x = 0;
  longint             m_sum_y = 0;
  longint             m_path = 0;
  logic [SCALE_W-1:0] m_scale = SCALE_RESET;

  int  mismatches = 0;
  int  pkts_queued = 0;
  int  results_checked = 0;
  int  n_finished = 0;
  int  n_overflow = 0;
  bit  idle_on = 1'b0;
  bit  pkt_taken = 1'b0;
  int  cfg_writes = 0;
  int  in_gap = 0;
  int  stall_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d packets unsent and %0d results outstanding",
             pkt_queue.size(), meas_queue.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint sat_acc(input longint v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  // scale a count sum to millimetres, truncating toward zero
  function automatic logic [ACC_WIDTH-1:0] counts_to_mm(input longint s);
    longint q;
    q = (((s < 0) ? -s : s) * longint'(m_scale)) >>> SCALE_FRAC;
    if (s < 0) begin
      if (q > -ACC_MIN) q = -ACC_MIN;
      return ACC_WIDTH'(-q);
    end
    if (q > ACC_MAX) q = ACC_MAX;
    return ACC_WIDTH'(q);
  endfunction

  function automatic res_t meter_apply(input pkt_t p);
    res_t   r;
    logic   left;
    longint dx, dy, len, path_mm;
    r = '0;
    left = |(p.status_byte & LEFT_MASK);
    dx = longint'(p.dx);
    dy = longint'(p.dy);
    if (m_phase == PH_WAIT || m_phase == PH_ENDED) begin
      m_sum_x = 0;
      m_sum_y = 0;
      m_path = 0;
      m_btn = left;
      m_phase = PH_ARMED;
    end else if (m_phase == PH_ARMED) begin
      // button change starts measuring, motion of this item is dropped
      if (left != m_btn) begin
        m_sum_x = 0;
        m_sum_y = 0;
        m_path = 0;
        m_phase = PH_MEAS;
      end
    end else begin
      len = longint'(int_sqrt(longint'(dx * dx + dy * dy) << (2 * PATH_FRAC_BITS)));
      m_sum_x = sat_acc(m_sum_x + dx);
      m_sum_y = sat_acc(m_sum_y + dy);
      m_path = (m_path + len > PATH_MAX) ? PATH_MAX : m_path + len;
      if (|(p.status_byte & OVF_MASK)) begin
        r.ovf_err = 1'b1;
        m_phase = PH_ENDED;
      end else if (left) begin
        r.finished = 1'b1;
        m_phase = PH_ENDED;
      end
    end
    path_mm = (m_path * longint'(m_scale)) >> SCALE_FRAC;
    r.phase = m_phase;
    r.sum_x = ACC_WIDTH'(m_sum_x);
    r.sum_y = ACC_WIDTH'(m_sum_y);
    r.x_mm = counts_to_mm(m_sum_x);
    r.y_mm = counts_to_mm(m_sum_y);
    r.path_mm_q8 = PATH_W'((path_mm > PATH_MAX) ? PATH_MAX : path_mm);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // driver: a stalled item is held, otherwise the next one goes out or a gap starts
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !pkt_taken) begin
      in_valid_i <= 1'b1;
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pkt_queue.size() > 0) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        in_gap <= $urandom_range(0, 12);
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pkt_queue[0];
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: check results first, then predict for the item taken at this edge
  always @(posedge clk_i) begin
    res_t want;
    pkt_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (meas_queue.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item pending, expected none, got %h",
                   $time, out_data_o);
        end else begin
          want = meas_queue.pop_front();
          results_checked++;
          check_field("phase", 32'(want.phase), 32'(out_data_o.phase));
          check_field("finished", 32'(want.finished), 32'(out_data_o.finished));
          check_field("ovf_err", 32'(want.ovf_err), 32'(out_data_o.ovf_err));
          check_field("sum_x", 32'(want.sum_x), 32'(out_data_o.sum_x));
          check_field("sum_y", 32'(want.sum_y), 32'(out_data_o.sum_y));
          check_field("x_mm", 32'(want.x_mm), 32'(out_data_o.x_mm));
          check_field("y_mm", 32'(want.y_mm), 32'(out_data_o.y_mm));
          check_field("path_mm_q8", want.path_mm_q8, out_data_o.path_mm_q8);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = meter_apply(in_data_i);
        if (want.finished) n_finished++;
        if (want.ovf_err) n_overflow++;
        meas_queue.push_back(want);
        void'(pkt_queue.pop_front());
      end
      if (cfg_valid_i && cfg_ready_o) begin
        m_scale = cfg_data_i;
        cfg_writes++;
      end
    end
  end

  task automatic push_pkt(input logic [7:0] st, input logic [7:0] dx, input logic [7:0] dy);
    pkt_t p;
    p.status_byte = st;
    p.dx = dx;
    p.dy = dy;
    pkt_queue.push_back(p);
    pkts_queued++;
  endtask

  // mostly whole measurements with random motion, some random noise
  task automatic push_sessions(input int n);
    int   goal;
    logic btn;
    goal = pkts_queued + n;
    while (pkts_queued < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        push_pkt(8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        btn = 1'($urandom);
        push_pkt({7'($urandom), btn}, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 2)) push_pkt({7'($urandom), btn}, 8'($urandom), 8'($urandom));
        push_pkt({7'($urandom), ~btn}, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 8))
          push_pkt({2'b00, 5'($urandom), 1'b0}, 8'($urandom), 8'($urandom));
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            push_pkt({2'b00, 5'($urandom), 1'b1}, 8'($urandom), 8'($urandom));
          end
          6, 7, 8: begin
            push_pkt({2'($urandom_range(1, 3)), 6'($urandom)}, 8'($urandom), 8'($urandom));
          end
          default: begin
            // left open, the next item lands mid measurement
          end
        endcase
      end
    end
  endtask

  task automatic drain();
    while (pkt_queue.size() != 0 || meas_queue.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    int n_before;
    n_before = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(negedge clk_i); while (cfg_writes == n_before);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    // directed items at the reset scale
    push_pkt(8'h00, 8'sd127, -8'sd128);
    push_pkt(8'hC0, 8'sd1, 8'sd1);       // overflow bits ignored while armed
    push_pkt(8'h01, -8'sd128, 8'sd127);  // start, motion dropped
    push_pkt(8'h3E, 8'sd127, 8'sd127);
    push_pkt(8'h00, -8'sd128, -8'sd128);
    push_pkt(8'h00, 8'sd0, 8'sd0);
    push_pkt(8'h01, 8'sd5, -8'sd3);      // finished
    push_pkt(8'h01, 8'sd9, 8'sd9);       // restart with button held
    push_pkt(8'h01, 8'sd2, 8'sd2);
    push_pkt(8'h00, 8'sd3, 8'sd3);
    push_pkt(8'h40, -8'sd7, 8'sd9);      // overflow error
    push_pkt(8'hFE, 8'sd0, 8'sd0);
    push_pkt(8'hFF, 8'sd4, 8'sd4);
    push_pkt(8'h81, 8'sd1, -8'sd1);      // overflow beats button
    push_pkt(8'h00, 8'sd0, 8'sd0);
    push_pkt(8'h01, 8'sd0, 8'sd0);
    push_pkt(8'h80, -8'sd128, 8'sd127);
    push_pkt(8'h00, 8'sd0, 8'sd0);
    push_pkt(8'h01, 8'sd0, 8'sd0);
    push_pkt(8'h00, 8'sd127, 8'sd0);
    push_pkt(8'hFE, 8'sd0, -8'sd128);
    drain();

    // short measurement at full scale with the largest motion per item
    write_scale(16'hFFFF);
    idle_on = 1'b0;
    push_pkt(8'h00, 8'sd0, 8'sd0);
    push_pkt(8'h01, 8'sd0, 8'sd0);
    repeat (20) push_pkt(8'h00, 8'sd127, -8'sd128);
    repeat (10) push_pkt(8'h00, -8'sd128, 8'sd127);
    push_pkt(8'h01, 8'sd0, 8'sd0);
    drain();

    idle_on = 1'b1;
    write_scale(16'h0000);
    push_sessions(150);
    drain();
    write_scale(16'h0001);
    push_sessions(150);
    drain();
    write_scale(16'($urandom));
    push_sessions(150);
    drain();
    idle_on = 1'b0;
    write_scale(SCALE_RESET);
    push_sessions(150);
    drain();

    $display("checked %0d results from %0d packets: %0d finished, %0d overflow ends",
             results_checked, pkts_queued, n_finished, n_overflow);
    $display("scales 1470, 65535, 0, 1 and a random one; full-range motion and stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
